// ===== sv/ffa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and defaults of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 32;

   localparam int          DEF_FREE_ENTRIES    = 32;
   localparam int          DEF_USED_ENTRIES    = 64;
   localparam logic [31:0] DEF_SUPERBLOCK_SIZE = 32'd1048576;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_ADD    = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOFIT    = 3'd1,
      ST_SUPER    = 3'd2,
      ST_NOTALLOC = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_INSERT = 2'd3
   } cmd_op_type;

   typedef enum logic {
      SCAN_FIT = 1'b0,
      SCAN_POS = 1'b1
   } scan_mode_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] len;
   } entry_type;

   typedef struct packed {
      cmd_op_type op;
      entry_type  data;
   } cmd_type;

   typedef struct packed {
      logic      found;
      entry_type cur;
      entry_type prev;
   } free_hit_type;

   typedef struct packed {
      logic              found;
      logic [SIZE_W-1:0] len;
      entry_type         last;
   } used_hit_type;

endpackage

// ===== sv/ffa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if
// Request and response channels of the allocator.
// ----------------------------------------------------------------------------
interface ffa_req_if;
   import ffa_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [ADDR_W-1:0] block_address;
   logic [SIZE_W-1:0] request_size;

   modport source (output valid, operation, block_address, request_size, input ready);
   modport sink   (input valid, operation, block_address, request_size, output ready);
endinterface

interface ffa_rsp_if;
   import ffa_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] result_address;
   logic [SIZE_W-1:0] result_size;
   logic [2:0]        status;

   modport source (output valid, result_address, result_size, status, input ready);
   modport sink   (input valid, result_address, result_size, status, output ready);
endinterface

// ===== sv/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// Alloc searches the free table, then updates the tables; add and free
// merge after the free search, and free searches the used table first.
// Failed checks before a search go straight to the result. Search chains pass
// one cell per cycle per table. One item at a time; the next is taken once
// the result is in the output register; synchronous reset empties both tables.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator with coalescing, built on rows of table cells.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int          FREE_ENTRIES    = ffa_pkg::DEF_FREE_ENTRIES,
   parameter int          USED_ENTRIES    = ffa_pkg::DEF_USED_ENTRIES,
   parameter logic [31:0] SUPERBLOCK_SIZE = ffa_pkg::DEF_SUPERBLOCK_SIZE
) (
   input logic        clock,
   input logic        reset,
   ffa_req_if.sink    req_ch,
   ffa_rsp_if.source  rsp_ch
);
   import ffa_pkg::*;

   localparam int IW = $clog2(FREE_ENTRIES+1);
   localparam int UW = $clog2(USED_ENTRIES+1);
   localparam int MX = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
   localparam int CW = $clog2(MX+1);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_USCAN  = 9'b000000010,
      S_FSCAN  = 9'b000000100,
      S_ALLOC  = 9'b000001000,
      S_MERGE1 = 9'b000010000,
      S_MERGE2 = 9'b000100000,
      S_EXEC1  = 9'b001000000,
      S_EXEC2  = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   addr_ff, addr_in, size_ff, size_in, qlen_ff, qlen_in;
   scan_mode_type mode_ff, mode_in;
   logic [IW-1:0] fcount_ff, fcount_in, fres_idx_ff, fres_idx_in;
   logic [UW-1:0] ucount_ff, ucount_in, ures_idx_ff, ures_idx_in;
   free_hit_type  fres_ff, fres_in;
   used_hit_type  ures_ff, ures_in;
   logic          mp_ff, mp_in;
   logic [31:0]   nb_ff, nb_in, nl_ff, nl_in;
   cmd_type       fcmd1_ff, fcmd1_in, fcmd2_ff, fcmd2_in, ucmd_ff, ucmd_in;
   logic [IW-1:0] fidx1_ff, fidx1_in, fidx2_ff, fidx2_in;
   logic [UW-1:0] uidx_ff, uidx_in;
   logic [31:0]   res_addr_ff, res_addr_in, res_size_ff, res_size_in;
   status_type    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_addr_ff, rsp_addr_in, rsp_size_ff, rsp_size_in;
   status_type    rsp_status_ff, rsp_status_in;

   cmd_type       fcmd, ucmd;
   logic [IW-1:0] fcmd_idx;
   logic [UW-1:0] ucmd_idx;

   entry_type     fdata [FREE_ENTRIES];
   free_hit_type  fhit  [FREE_ENTRIES];
   logic [IW-1:0] fidx  [FREE_ENTRIES];
   used_hit_type  uhit  [USED_ENTRIES];
   logic [UW-1:0] uidx  [USED_ENTRIES];

   logic [32:0]   room;
   logic [31:0]   clip_len;
   logic [32:0]   pend, psum, nend, nsum;
   logic          has_prev, has_cur, mn;

   // ---- cell rows ----
   genvar g;
   generate
      for (g = 0; g < FREE_ENTRIES; g++) begin : g_free
         free_hit_type  hit_l;
         logic [IW-1:0] idx_l;
         entry_type     left_d, right_d;
         if (g == 0) begin : g_head
            assign hit_l  = '0;
            assign idx_l  = '0;
            assign left_d = fdata[g];
         end else begin : g_body
            assign hit_l  = fhit[g-1];
            assign idx_l  = fidx[g-1];
            assign left_d = fdata[g-1];
         end
         if (g == FREE_ENTRIES-1) begin : g_tail
            assign right_d = fdata[g];
         end else begin : g_inner
            assign right_d = fdata[g+1];
         end
         ffa_free_cell #(.FREE_ENTRIES(FREE_ENTRIES), .INDEX(g)) u_cell (
            .clock        (clock),
            .cmd          (fcmd),
            .cmd_idx      (fcmd_idx),
            .count        (fcount_ff),
            .mode         (mode_ff),
            .qbase        (addr_ff),
            .qsize        (size_ff),
            .left_data    (left_d),
            .right_data   (right_d),
            .scan_in      (hit_l),
            .scan_in_idx  (idx_l),
            .scan_out     (fhit[g]),
            .scan_out_idx (fidx[g]),
            .data_out     (fdata[g])
         );
      end
      for (g = 0; g < USED_ENTRIES; g++) begin : g_used
         used_hit_type  hit_l;
         logic [UW-1:0] idx_l;
         if (g == 0) begin : g_head
            assign hit_l = '0;
            assign idx_l = '0;
         end else begin : g_body
            assign hit_l = uhit[g-1];
            assign idx_l = uidx[g-1];
         end
         ffa_used_cell #(.USED_ENTRIES(USED_ENTRIES), .INDEX(g)) u_cell (
            .clock        (clock),
            .cmd          (ucmd),
            .cmd_idx      (ucmd_idx),
            .count        (ucount_ff),
            .qaddr        (addr_ff),
            .scan_in      (hit_l),
            .scan_in_idx  (idx_l),
            .scan_out     (uhit[g]),
            .scan_out_idx (uidx[g])
         );
      end
   endgenerate

   // ---- command issue ----
   always_comb begin
      fcmd     = '0;
      fcmd_idx = fidx1_ff;
      ucmd     = '0;
      ucmd_idx = uidx_ff;
      if (state_ff == S_EXEC1) begin
         fcmd = fcmd1_ff;
         ucmd = ucmd_ff;
      end else if (state_ff == S_EXEC2) begin
         fcmd     = fcmd2_ff;
         fcmd_idx = fidx2_ff;
      end
   end

   // region length clipped at the top of the address space
   assign room     = 33'h1_0000_0000 - {1'b0, req_ch.block_address};
   assign clip_len = ({1'b0, req_ch.request_size} > room) ? room[31:0]
                                                          : req_ch.request_size;

   assign has_prev = fres_idx_ff != '0;
   assign pend     = {1'b0, fres_ff.prev.base} + {1'b0, fres_ff.prev.len};
   assign psum     = {1'b0, fres_ff.prev.len} + {1'b0, qlen_ff};
   assign has_cur  = fres_idx_ff < fcount_ff;
   assign nend     = {1'b0, nb_ff} + {1'b0, nl_ff};
   assign nsum     = {1'b0, nl_ff} + {1'b0, fres_ff.cur.len};
   assign mn       = has_cur && nend == {1'b0, fres_ff.cur.base} && !nsum[32];

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      qlen_in       = qlen_ff;
      mode_in       = mode_ff;
      fcount_in     = fcount_ff;
      ucount_in     = ucount_ff;
      fres_in       = fres_ff;
      fres_idx_in   = fres_idx_ff;
      ures_in       = ures_ff;
      ures_idx_in   = ures_idx_ff;
      mp_in         = mp_ff;
      nb_in         = nb_ff;
      nl_in         = nl_ff;
      fcmd1_in      = fcmd1_ff;
      fcmd2_in      = fcmd2_ff;
      ucmd_in       = ucmd_ff;
      fidx1_in      = fidx1_ff;
      fidx2_in      = fidx2_ff;
      uidx_in       = uidx_ff;
      res_addr_in   = res_addr_ff;
      res_size_in   = res_size_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_ch.operation;
               addr_in       = req_ch.block_address;
               size_in       = req_ch.request_size;
               mode_in       = SCAN_POS;
               cnt_in        = CW'(FREE_ENTRIES);
               res_addr_in   = '0;
               res_size_in   = '0;
               res_status_in = ST_OK;
               case (req_ch.operation)
                  OP_ALLOC: begin
                     if (req_ch.request_size >= SUPERBLOCK_SIZE) begin
                        res_status_in = ST_SUPER;
                        state_in      = S_DONE;
                     end else if (req_ch.request_size == '0) begin
                        res_status_in = ST_NOFIT;
                        state_in      = S_DONE;
                     end else if (ucount_ff == UW'(USED_ENTRIES)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else begin
                        mode_in  = SCAN_FIT;
                        state_in = S_FSCAN;
                     end
                  end
                  OP_FREE: begin
                     cnt_in   = CW'(USED_ENTRIES);
                     state_in = S_USCAN;
                  end
                  OP_ADD: begin
                     if (req_ch.request_size == '0) begin
                        res_addr_in = req_ch.block_address;
                        state_in    = S_DONE;
                     end else begin
                        qlen_in  = clip_len;
                        state_in = S_FSCAN;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_USCAN: begin
            if (cnt_ff == '0) begin
               if (!uhit[USED_ENTRIES-1].found) begin
                  res_status_in = ST_NOTALLOC;
                  state_in      = S_DONE;
               end else begin
                  ures_in     = uhit[USED_ENTRIES-1];
                  ures_idx_in = uidx[USED_ENTRIES-1];
                  qlen_in     = uhit[USED_ENTRIES-1].len;
                  cnt_in      = CW'(FREE_ENTRIES);
                  state_in    = S_FSCAN;
               end
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FSCAN: begin
            if (cnt_ff == '0) begin
               fres_in     = fhit[FREE_ENTRIES-1];
               fres_idx_in = fidx[FREE_ENTRIES-1];
               if (!fhit[FREE_ENTRIES-1].found) begin
                  fres_idx_in  = IW'(FREE_ENTRIES);
                  fres_in.prev = fdata[FREE_ENTRIES-1];
               end
               state_in = (op_ff == OP_ALLOC) ? S_ALLOC : S_MERGE1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_ALLOC: begin
            if (!fres_ff.found) begin
               res_status_in = ST_NOFIT;
               state_in      = S_DONE;
            end else begin
               fidx1_in = fres_idx_ff;
               if (fres_ff.cur.len > size_ff) begin
                  fcmd1_in.op        = CMD_WRITE;
                  fcmd1_in.data.base = fres_ff.cur.base + size_ff;
                  fcmd1_in.data.len  = fres_ff.cur.len - size_ff;
               end else begin
                  fcmd1_in.op = CMD_REMOVE;
                  fcount_in   = fcount_ff - 1'b1;
               end
               fcmd2_in.op        = CMD_NONE;
               ucmd_in.op         = CMD_WRITE;
               ucmd_in.data.base  = fres_ff.cur.base;
               ucmd_in.data.len   = size_ff;
               uidx_in            = ucount_ff;
               ucount_in          = ucount_ff + 1'b1;
               res_addr_in        = fres_ff.cur.base;
               res_size_in        = size_ff;
               state_in           = S_EXEC1;
            end
         end
         S_MERGE1: begin
            mp_in = has_prev && pend == {1'b0, addr_ff} && !psum[32];
            if (has_prev && pend == {1'b0, addr_ff} && !psum[32]) begin
               nb_in = fres_ff.prev.base;
               nl_in = psum[31:0];
            end else begin
               nb_in = addr_ff;
               nl_in = qlen_ff;
            end
            state_in = S_MERGE2;
         end
         S_MERGE2: begin
            if (!mp_ff && !mn && fcount_ff == IW'(FREE_ENTRIES)) begin
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end else begin
               fcmd2_in.op = CMD_NONE;
               fidx2_in    = fres_idx_ff;
               res_addr_in = nb_ff;
               if (mp_ff && mn) begin
                  fcmd1_in.op   = CMD_WRITE;
                  fidx1_in      = fres_idx_ff - 1'b1;
                  fcmd1_in.data = '{base: nb_ff, len: nsum[31:0]};
                  fcmd2_in.op   = CMD_REMOVE;
                  fcount_in     = fcount_ff - 1'b1;
                  res_size_in   = nsum[31:0];
               end else if (mp_ff) begin
                  fcmd1_in.op   = CMD_WRITE;
                  fidx1_in      = fres_idx_ff - 1'b1;
                  fcmd1_in.data = '{base: nb_ff, len: nl_ff};
                  res_size_in   = nl_ff;
               end else if (mn) begin
                  fcmd1_in.op   = CMD_WRITE;
                  fidx1_in      = fres_idx_ff;
                  fcmd1_in.data = '{base: nb_ff, len: nsum[31:0]};
                  res_size_in   = nsum[31:0];
               end else begin
                  fcmd1_in.op   = CMD_INSERT;
                  fidx1_in      = fres_idx_ff;
                  fcmd1_in.data = '{base: nb_ff, len: nl_ff};
                  fcount_in     = fcount_ff + 1'b1;
                  res_size_in   = nl_ff;
               end
               if (op_ff == OP_FREE) begin
                  // move the last allocated entry into the freed slot
                  ucmd_in.op   = CMD_WRITE;
                  ucmd_in.data = ures_ff.last;
                  uidx_in      = ures_idx_ff;
                  ucount_in    = ucount_ff - 1'b1;
               end else begin
                  ucmd_in.op = CMD_NONE;
               end
               state_in = S_EXEC1;
            end
         end
         S_EXEC1: state_in = S_EXEC2;
         S_EXEC2: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_size_in   = res_size_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fcount_ff    <= '0;
         ucount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fcount_ff    <= fcount_in;
         ucount_ff    <= ucount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      qlen_ff       <= qlen_in;
      mode_ff       <= mode_in;
      fres_ff       <= fres_in;
      fres_idx_ff   <= fres_idx_in;
      ures_ff       <= ures_in;
      ures_idx_ff   <= ures_idx_in;
      mp_ff         <= mp_in;
      nb_ff         <= nb_in;
      nl_ff         <= nl_in;
      fcmd1_ff      <= fcmd1_in;
      fcmd2_ff      <= fcmd2_in;
      ucmd_ff       <= ucmd_in;
      fidx1_ff      <= fidx1_in;
      fidx2_ff      <= fidx2_in;
      uidx_ff       <= uidx_in;
      res_addr_ff   <= res_addr_in;
      res_size_ff   <= res_size_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ch.ready          = state_ff == S_IDLE;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_address = rsp_addr_ff;
   assign rsp_ch.result_size    = rsp_size_ff;
   assign rsp_ch.status         = rsp_status_ff;

   a_fcount_range: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= IW'(FREE_ENTRIES))
      else $error("free count out of range");

   a_ucount_range: assert property (@(posedge clock) disable iff (reset)
      ucount_ff <= UW'(USED_ENTRIES))
      else $error("used count out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |->
         rsp_addr_ff == '0 && rsp_size_ff == '0)
      else $error("failed item carries nonzero payload");

   a_fcount_src: assert property (@(posedge clock) disable iff (reset)
      fcount_ff != $past(fcount_ff) |->
         ($past(state_ff) == S_ALLOC || $past(state_ff) == S_MERGE2))
      else $error("free count changed outside a table update");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready) |=>
         rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not loaded into output register");

endmodule

// ===== sv/ffa_free_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_free_cell
// One free-list entry: shifts with its neighbors, joins the search chain.
// ----------------------------------------------------------------------------
module ffa_free_cell #(
   parameter int FREE_ENTRIES = ffa_pkg::DEF_FREE_ENTRIES,
   parameter int INDEX        = 0
) (
   input  logic                                  clock,
   input  ffa_pkg::cmd_type                      cmd,
   input  logic [$clog2(FREE_ENTRIES+1)-1:0]     cmd_idx,
   input  logic [$clog2(FREE_ENTRIES+1)-1:0]     count,
   input  ffa_pkg::scan_mode_type                mode,
   input  logic [ffa_pkg::ADDR_W-1:0]            qbase,
   input  logic [ffa_pkg::SIZE_W-1:0]            qsize,
   input  ffa_pkg::entry_type                    left_data,
   input  ffa_pkg::entry_type                    right_data,
   input  ffa_pkg::free_hit_type                 scan_in,
   input  logic [$clog2(FREE_ENTRIES+1)-1:0]     scan_in_idx,
   output ffa_pkg::free_hit_type                 scan_out,
   output logic [$clog2(FREE_ENTRIES+1)-1:0]     scan_out_idx,
   output ffa_pkg::entry_type                    data_out
);
   import ffa_pkg::*;

   localparam int IW = $clog2(FREE_ENTRIES+1);
   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   entry_type    entry_ff, entry_in;
   free_hit_type hit_ff, hit_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic         valid, match;

   assign valid = MY_IDX < count;
   assign match = (mode == SCAN_FIT) ? (valid && entry_ff.len >= qsize)
                                     : (!valid || entry_ff.base >= qbase);

   always_comb begin
      hit_in = scan_in;
      idx_in = scan_in_idx;
      if (!scan_in.found && match) begin
         hit_in.found = 1'b1;
         hit_in.cur   = entry_ff;
         hit_in.prev  = left_data;
         idx_in       = MY_IDX;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CMD_WRITE:  if (cmd_idx == MY_IDX) entry_in = cmd.data;
         CMD_REMOVE: if (MY_IDX >= cmd_idx) entry_in = right_data;
         CMD_INSERT: begin
            if (MY_IDX > cmd_idx)       entry_in = left_data;
            else if (MY_IDX == cmd_idx) entry_in = cmd.data;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
      idx_ff   <= idx_in;
   end

   assign scan_out     = hit_ff;
   assign scan_out_idx = idx_ff;
   assign data_out     = entry_ff;

endmodule

// ===== sv/ffa_used_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_used_cell
// One allocated-block entry: address match and last-entry pickup in the chain.
// ----------------------------------------------------------------------------
module ffa_used_cell #(
   parameter int USED_ENTRIES = ffa_pkg::DEF_USED_ENTRIES,
   parameter int INDEX        = 0
) (
   input  logic                                  clock,
   input  ffa_pkg::cmd_type                      cmd,
   input  logic [$clog2(USED_ENTRIES+1)-1:0]     cmd_idx,
   input  logic [$clog2(USED_ENTRIES+1)-1:0]     count,
   input  logic [ffa_pkg::ADDR_W-1:0]            qaddr,
   input  ffa_pkg::used_hit_type                 scan_in,
   input  logic [$clog2(USED_ENTRIES+1)-1:0]     scan_in_idx,
   output ffa_pkg::used_hit_type                 scan_out,
   output logic [$clog2(USED_ENTRIES+1)-1:0]     scan_out_idx
);
   import ffa_pkg::*;

   localparam int UW = $clog2(USED_ENTRIES+1);
   localparam logic [UW-1:0] MY_IDX  = UW'(INDEX);
   localparam logic [UW-1:0] MY_NEXT = UW'(INDEX + 1);

   entry_type     entry_ff, entry_in;
   used_hit_type  hit_ff, hit_in;
   logic [UW-1:0] idx_ff, idx_in;
   logic          match;

   assign match = (MY_IDX < count) && (entry_ff.base == qaddr);

   always_comb begin
      hit_in = scan_in;
      idx_in = scan_in_idx;
      if (!scan_in.found && match) begin
         hit_in.found = 1'b1;
         hit_in.len   = entry_ff.len;
         idx_in       = MY_IDX;
      end
      if (MY_NEXT == count) hit_in.last = entry_ff;
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.op == CMD_WRITE && cmd_idx == MY_IDX) entry_in = cmd.data;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
      idx_ff   <= idx_in;
   end

   assign scan_out     = hit_ff;
   assign scan_out_idx = idx_ff;

endmodule
